/* src/vzc_pkg.sv */
// ----------------------------------------------------------------------------
// vzc_pkg: shared types and constants of the varint / zigzag codec
// Holds the controller state type, the command and status bundles between
// controller and datapath, and the codec constants.
// ----------------------------------------------------------------------------
package vzc_pkg;

  // Field widths
  localparam int VALUE_W   = 64;
  localparam int BYTE_W    = 8;
  localparam int GROUP_W   = 7;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;

  // Byte format
  localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7f;

  // Width masks
  localparam logic [VALUE_W-1:0] MASK_NARROW = 64'h0000_0000_ffff_ffff;
  localparam logic [VALUE_W-1:0] MASK_WIDE   = 64'hffff_ffff_ffff_ffff;

  // Byte counts: encode index of the tenth byte, decode byte limits
  localparam logic [CNT_W-1:0] ENC_LAST_IDX     = 4'd9;
  localparam logic [CNT_W-1:0] DEC_LIMIT_WIDE   = 4'd10;
  localparam logic [CNT_W-1:0] DEC_LIMIT_NARROW = 4'd5;

  // Function codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZIGZAG_ON = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } vzc_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic enc_load;     // capture a value to encode
    logic enc_step;     // emit one encoded byte and shift
    logic dec_step;     // fold one byte into the accumulator
    logic out_load;     // load the result register
    logic out_sel_dec;  // result register takes the decoded value
  } vzc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic enc_more;     // current encode byte is not the final one
    logic dec_done;     // presented byte completes a value
  } vzc_stat_t;

endpackage

/* src/vzc_in_if.sv */
// ----------------------------------------------------------------------------
// vzc_in_if: input item channel
// Valid/ready channel carrying one encode value or one decode byte.
// ----------------------------------------------------------------------------
interface vzc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] value;
  logic [7:0]  in_byte;

  modport source (output valid, output func, output value, output in_byte, input ready);
  modport sink (input valid, input func, input value, input in_byte, output ready);
endinterface

/* src/vzc_out_if.sv */
// ----------------------------------------------------------------------------
// vzc_out_if: result channel
// Valid/ready channel carrying one encoded byte or one decoded value.
// ----------------------------------------------------------------------------
interface vzc_out_if;
  logic        valid;
  logic        ready;
  logic        is_value;
  logic [7:0]  out_byte;
  logic [63:0] out_value;
  logic        last;

  modport source (output valid, output is_value, output out_byte, output out_value,
                  output last, input ready);
  modport sink (input valid, input is_value, input out_byte, input out_value,
                input last, output ready);
endinterface

/* src/vzc_ctrl.sv */
// ----------------------------------------------------------------------------
// vzc_ctrl: codec controller
// Sequences input transfers, encode byte emission and the result register
// occupancy, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module vzc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_func,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  vzc_pkg::vzc_stat_t stat,
  output vzc_pkg::vzc_cmd_t  cmd
);
  import vzc_pkg::*;

  vzc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       in_xfer;

  // Result register can take a new entry when empty or being drained
  assign slot_free = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // State and result occupancy registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (in_func == FUNC_ENCODE) begin
            cmd.enc_load = 1'b1;
            state_nxt    = ST_ENC;
          end else begin
            cmd.dec_step    = 1'b1;
            cmd.out_load    = stat.dec_done;
            cmd.out_sel_dec = 1'b1;
          end
        end
      end
      ST_ENC: begin
        if (slot_free) begin
          cmd.enc_step = 1'b1;
          cmd.out_load = 1'b1;
          if (!stat.enc_more) begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // An encode transfer always starts byte emission
  a_enc_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_func == FUNC_ENCODE) |=> state_r == ST_ENC)
    else $error("encode transfer did not start emission");

  // A result only appears after a load command
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result valid without load");

  // Emission never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_valid_r) |-> out_ready)
    else $error("result register overwritten");

endmodule

/* src/vzc_dp.sv */
// ----------------------------------------------------------------------------
// vzc_dp: codec datapath
// Holds the configuration registers, the encode shift register, the decode
// accumulator and the result register.
// ----------------------------------------------------------------------------
module vzc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vzc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [vzc_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic [vzc_pkg::VALUE_W-1:0]       in_value,
  input  logic [vzc_pkg::BYTE_W-1:0]        in_byte,
  input  vzc_pkg::vzc_cmd_t                 cmd,
  output vzc_pkg::vzc_stat_t                stat,
  output logic                              out_is_value,
  output logic [vzc_pkg::BYTE_W-1:0]        out_byte,
  output logic [vzc_pkg::VALUE_W-1:0]       out_value,
  output logic                              out_last
);
  import vzc_pkg::*;

  logic                 wide_mode_r;
  logic                 zigzag_on_r;
  logic [VALUE_W-1:0]   enc_u_r, enc_u_nxt;
  logic [CNT_W-1:0]     enc_cnt_r;
  logic [VALUE_W-1:0]   dec_acc_r, dec_acc_nxt;
  logic [CNT_W-1:0]     dec_cnt_r, dec_cnt_nxt;
  logic                 res_is_value_r;
  logic [BYTE_W-1:0]    res_byte_r;
  logic [VALUE_W-1:0]   res_value_r;
  logic                 res_last_r;

  logic [VALUE_W-1:0]   width_mask;
  logic [VALUE_W-1:0]   enc_masked;
  logic                 enc_sign;
  logic                 enc_more;
  logic [BYTE_W-1:0]    enc_byte;
  logic [CNT_W+2:0]     dec_shamt;
  logic [VALUE_W-1:0]   dec_group;
  logic [CNT_W-1:0]     dec_limit;
  logic                 dec_done;
  logic [VALUE_W-1:0]   dec_unmap;
  logic [VALUE_W-1:0]   dec_value;

  assign width_mask = wide_mode_r ? MASK_WIDE : MASK_NARROW;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_mode_r <= 1'b1;
      zigzag_on_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WIDE_MODE: wide_mode_r <= cfg_data[0];
        CFG_ZIGZAG_ON: zigzag_on_r <= cfg_data[0];
      endcase
    end
  end

  // Encode: mask to width, then optional zigzag mapping
  always_comb begin
    enc_masked = in_value & width_mask;
    enc_sign   = wide_mode_r ? in_value[VALUE_W-1] : in_value[31];
    if (zigzag_on_r) begin
      enc_u_nxt = ({enc_masked[VALUE_W-2:0], 1'b0} ^ {VALUE_W{enc_sign}}) & width_mask;
    end else begin
      enc_u_nxt = enc_masked;
    end
  end

  // Encode byte of the current group
  assign enc_more = (enc_u_r[VALUE_W-1:GROUP_W] != '0) && (enc_cnt_r != ENC_LAST_IDX);
  assign enc_byte = enc_more ? ((enc_u_r[BYTE_W-1:0] & GROUP_MASK) | CONT_BIT)
                             : enc_u_r[BYTE_W-1:0];

  // Encode shift register: load on transfer, advance one group per byte
  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      enc_u_r   <= enc_u_nxt;
      enc_cnt_r <= '0;
    end else if (cmd.enc_step) begin
      enc_u_r   <= enc_u_r >> GROUP_W;
      enc_cnt_r <= enc_cnt_r + 1'b1;
    end
  end

  // Decode: place the byte's group at seven times the byte count
  always_comb begin
    dec_shamt = {dec_cnt_r, 3'b000} - {3'b000, dec_cnt_r};
    if (dec_cnt_r < DEC_LIMIT_WIDE) begin
      dec_group = {{(VALUE_W-GROUP_W){1'b0}}, in_byte[GROUP_W-1:0]} << dec_shamt[5:0];
    end else begin
      dec_group = '0;
    end
    dec_acc_nxt = (dec_acc_r | dec_group) & width_mask;
    dec_cnt_nxt = dec_cnt_r + 1'b1;
    dec_limit   = wide_mode_r ? DEC_LIMIT_WIDE : DEC_LIMIT_NARROW;
    dec_done    = !in_byte[BYTE_W-1] || (dec_cnt_nxt >= dec_limit);
  end

  // Status to the controller
  assign stat = '{enc_more: enc_more, dec_done: dec_done};

  // Decode: undo zigzag and, with zigzag on, sign-extend a narrow result
  always_comb begin
    dec_unmap = {1'b0, dec_acc_nxt[VALUE_W-1:1]} ^ {VALUE_W{dec_acc_nxt[0]}};
    if (!zigzag_on_r) begin
      dec_value = dec_acc_nxt;
    end else if (wide_mode_r) begin
      dec_value = dec_unmap;
    end else begin
      dec_value = {{32{dec_unmap[31]}}, dec_unmap[31:0]};
    end
  end

  // Decode accumulator: clear once a value completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_acc_r <= '0;
      dec_cnt_r <= '0;
    end else if (cmd.dec_step) begin
      if (stat.dec_done) begin
        dec_acc_r <= '0;
        dec_cnt_r <= '0;
      end else begin
        dec_acc_r <= dec_acc_nxt;
        dec_cnt_r <= dec_cnt_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel_dec) begin
        res_is_value_r <= 1'b1;
        res_byte_r     <= '0;
        res_value_r    <= dec_value;
        res_last_r     <= 1'b1;
      end else begin
        res_is_value_r <= 1'b0;
        res_byte_r     <= enc_byte;
        res_value_r    <= '0;
        res_last_r     <= !stat.enc_more;
      end
    end
  end

  assign out_is_value = res_is_value_r;
  assign out_byte     = res_byte_r;
  assign out_value    = res_value_r;
  assign out_last     = res_last_r;

  // Decode count never passes the wide limit
  a_dec_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    dec_cnt_r < DEC_LIMIT_WIDE)
    else $error("decode count out of range");

  // A completed value leaves the byte count cleared
  a_dec_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.dec_step && stat.dec_done) |=> dec_cnt_r == '0)
    else $error("decode count not cleared after a value");

  // The final encoded byte never carries the continuation bit
  a_enc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cmd.out_sel_dec && !stat.enc_more) |=> !res_byte_r[BYTE_W-1])
    else $error("final encoded byte has continuation bit");

endmodule

/* src/varint_zigzag_codec_top.sv */
// ----------------------------------------------------------------------------
// varint_zigzag_codec_top: 7-bit varint codec with zigzag mapping
// Encodes 32/64-bit values to 1..10 bytes and decodes byte streams back to
// values, with optional zigzag signed mapping.
//
//   channel | direction | payload
//   --------+-----------+--------------------------------------------
//   in_ch   | sink      | func, value, in_byte
//   out_ch  | source    | is_value, out_byte, out_value, last
//   cfg_*   | write     | wide_mode (index 0), zigzag_on (index 1)
//
// A decode item is folded into the accumulator; a value leaves in the result register.
// An encode item is captured and then emitted one byte at a time from the
// single encode shift register, which takes no new item until the last byte.
// The result register parts input and output: a new item is taken while the
// waiting result is transferred. Output stalls hold emission in place.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module varint_zigzag_codec_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vzc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vzc_pkg::CFG_DAT_W-1:0] cfg_data,
  vzc_in_if.sink                        in_ch,
  vzc_out_if.source                     out_ch
);
  import vzc_pkg::*;

  vzc_cmd_t  cmd;
  vzc_stat_t stat;

  // Controller
  vzc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  vzc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_value     (in_ch.value),
    .in_byte      (in_ch.in_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_is_value (out_ch.is_value),
    .out_byte     (out_ch.out_byte),
    .out_value    (out_ch.out_value),
    .out_last     (out_ch.last)
  );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the varint / zigzag codec
// Sends encode values and decode bytes over the input channel, computes the
// encoded bytes and decoded values the codec must return, and compares every
// result transfer field by field. Runs directed edge cases, then random
// traffic (mostly well-formed byte streams) under all width/zigzag settings.
// Random input gaps and result stalls apply to all but the first random run.
// ----------------------------------------------------------------------------
module tb_top;
  import vzc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLE = 4;

  typedef struct packed {
    logic        is_value;
    logic [7:0]  enc_byte;
    logic [63:0] dec_value;
    logic        last;
  } codec_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;

  vzc_in_if  in_ch();
  vzc_out_if out_ch();

  varint_zigzag_codec_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Mirror of the codec registers and decode accumulator
  logic          mode_wide;
  logic          mode_zigzag;
  logic [63:0]   acc_bits;
  logic [3:0]    acc_count;
  codec_result_t codec_outputs_due[$];
  codec_result_t want_result;

  bit idle_enabled;
  int stall_cnt;
  int error_count;
  int cycle_count;
  int results_checked;
  int enc_items;
  int dec_items;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Append one expected result to the tail of the pending list
  function automatic void expect_result(codec_result_t r);
    codec_outputs_due = {codec_outputs_due, r};
  endfunction

  // Compute the results one accepted item produces, and advance the mirror state
  function automatic void codec_compute(logic f, logic [63:0] v, logic [7:0] b);
    logic [63:0] mask;
    logic [63:0] u;
    logic [3:0]  limit;
    int          n;
    int          shift;
    mask = mode_wide ? MASK_WIDE : MASK_NARROW;
    if (f == FUNC_ENCODE) begin
      u = v & mask;
      if (mode_zigzag)
        u = ((u << 1) ^ {64{mode_wide ? u[63] : u[31]}}) & mask;
      n = 0;
      while (u >= {56'd0, CONT_BIT} && n < 9) begin
        expect_result(codec_result_t'{1'b0, (u[7:0] & GROUP_MASK) | CONT_BIT,
                                      64'd0, 1'b0});
        u = u >> GROUP_W;
        n++;
      end
      expect_result(codec_result_t'{1'b0, u[7:0], 64'd0, 1'b1});
    end else begin
      shift = int'(acc_count) * GROUP_W;
      if (shift < VALUE_W)
        acc_bits = acc_bits | ({56'd0, b & GROUP_MASK} << shift);
      acc_bits  = acc_bits & mask;
      acc_count = acc_count + 4'd1;
      limit     = mode_wide ? DEC_LIMIT_WIDE : DEC_LIMIT_NARROW;
      // hold: the value is still open
      if ((b & CONT_BIT) != 8'd0 && acc_count < limit)
        return;
      u = acc_bits;
      if (mode_zigzag) begin
        u = (u >> 1) ^ {64{u[0]}};
        if (!mode_wide) begin
          u = u & MASK_NARROW;
          if (u[31])
            u = u | ~MASK_NARROW;
        end
      end
      acc_bits  = 64'd0;
      acc_count = 4'd0;
      expect_result(codec_result_t'{1'b1, 8'd0, u, 1'b1});
    end
  endfunction

  // Result side: random stalls, short mostly, now and then a long one
  always @(negedge clk) begin
    if (!idle_enabled || !rst_n) begin
      stall_cnt    <= 0;
      out_ch.ready <= rst_n;
    end else if (stall_cnt > 0) begin
      stall_cnt    <= stall_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:29]:  stall_cnt <= $urandom_range(1, 3);
        [30:32]: stall_cnt <= $urandom_range(15, 40);
        default: stall_cnt <= 0;
      endcase
    end
  end

  // Compare each result transfer with the oldest pending result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (codec_outputs_due.size() == 0) begin
        error_count++;
        $display("%0t: result with none pending: is_value %b byte %h value %h last %b",
                 $time, out_ch.is_value, out_ch.out_byte, out_ch.out_value, out_ch.last);
      end else begin
        want_result = codec_outputs_due.pop_front();
        results_checked++;
        if (out_ch.is_value !== want_result.is_value) begin
          error_count++;
          $display("%0t: is_value expected %b actual %b",
                   $time, want_result.is_value, out_ch.is_value);
        end
        if (out_ch.out_byte !== want_result.enc_byte) begin
          error_count++;
          $display("%0t: out_byte expected %h actual %h",
                   $time, want_result.enc_byte, out_ch.out_byte);
        end
        if (out_ch.out_value !== want_result.dec_value) begin
          error_count++;
          $display("%0t: out_value expected %h actual %h",
                   $time, want_result.dec_value, out_ch.out_value);
        end
        if (out_ch.last !== want_result.last) begin
          error_count++;
          $display("%0t: last expected %b actual %b", $time, want_result.last, out_ch.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, codec_outputs_due.size());
      $display("FAIL varint_zigzag_codec_top");
      $finish;
    end
  end

  // Send one item: optional gap, then hold valid until the transfer
  task automatic send_item(input logic f, input logic [63:0] v, input logic [7:0] b);
    int gap;
    gap = 0;
    if (idle_enabled) begin
      case ($urandom_range(0, 99)) inside
        [0:49]:  gap = 0;
        [50:84]: gap = $urandom_range(1, 3);
        [85:96]: gap = $urandom_range(4, 10);
        default: gap = $urandom_range(20, 40);
      endcase
    end
    repeat (gap) @(negedge clk);
    in_ch.func    = f;
    in_ch.value   = v;
    in_ch.in_byte = b;
    in_ch.valid   = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    codec_compute(f, v, b);
    if (f == FUNC_ENCODE)
      enc_items++;
    else
      dec_items++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Hold the sender until every pending result has come, then let the codec settle
  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (codec_outputs_due.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk);
    if (idx == CFG_WIDE_MODE)
      mode_wide = data;
    else if (idx == CFG_ZIGZAG_ON)
      mode_zigzag = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Shortest and longest encodings at reset settings (64-bit, plain)
  task automatic test_encode_extremes();
    send_item(FUNC_ENCODE, 64'd0, 8'h00);
    send_item(FUNC_ENCODE, 64'd128, 8'hff);
    send_item(FUNC_ENCODE, MASK_WIDE, 8'h00);
  endtask

  // Ten bytes all with the top bit set: the tenth closes the value anyway
  task automatic test_decode_tenth_byte();
    repeat (10) send_item(FUNC_DECODE, MASK_WIDE, 8'hff);
  endtask

  // Zigzag on the most negative value and -1 at 64-bit, and on the most negative and most positive at 32-bit
  task automatic test_zigzag_extremes();
    wait_drain();
    write_reg(CFG_ZIGZAG_ON, 1'b1);
    send_item(FUNC_ENCODE, 64'h8000_0000_0000_0000, 8'h00);
    send_item(FUNC_ENCODE, MASK_WIDE, 8'hff);
    wait_drain();
    write_reg(CFG_WIDE_MODE, 1'b0);
    send_item(FUNC_ENCODE, 64'h0000_0000_8000_0000, 8'h00);
    send_item(FUNC_ENCODE, 64'hffff_ffff_7fff_ffff, 8'h00);
    // fifth byte closes the 32-bit value; sign extends after unmapping
    repeat (5) send_item(FUNC_DECODE, 64'd0, 8'hff);
  endtask

  // Five bytes gathered at 64-bit, then narrow: the next byte must close
  task automatic test_width_switch_mid_value();
    wait_drain();
    write_reg(CFG_WIDE_MODE, 1'b1);
    write_reg(CFG_ZIGZAG_ON, 1'b0);
    for (int i = 1; i <= 5; i++)
      send_item(FUNC_DECODE, 64'd0, CONT_BIT | 8'(i));
    wait_drain();
    write_reg(CFG_WIDE_MODE, 1'b0);
    send_item(FUNC_DECODE, 64'd0, 8'h86);
  endtask

  // Random traffic: well-formed byte streams, encodes (some inside streams), noise
  task automatic test_random_traffic(input bit wide, input bit zz, input bit idle,
                                     input int n_items);
    int          sent;
    int          len;
    int          limit;
    int          k;
    logic [63:0] v;
    logic        top;
    wait_drain();
    write_reg(CFG_WIDE_MODE, wide);
    write_reg(CFG_ZIGZAG_ON, zz);
    idle_enabled = idle;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 99)) inside
        [0:34]: begin
          k = $urandom_range(0, 64);
          v = {$urandom, $urandom};
          case ($urandom_range(0, 4))
            0: ;
            1: if (k < 64) v = v & ((64'd1 << k) - 64'd1);
            2: v = -(v & ((64'd1 << (k % 21)) - 64'd1));
            3: begin
              case ($urandom_range(0, 5))
                0: v = 64'd0;
                1: v = MASK_WIDE;
                2: v = 64'h8000_0000_0000_0000;
                3: v = 64'h7fff_ffff_ffff_ffff;
                4: v = 64'h0000_0000_8000_0000;
                default: v = 64'h0000_0000_7fff_ffff;
              endcase
            end
            default: v = 64'($urandom_range(0, 300));
          endcase
          send_item(FUNC_ENCODE, v, 8'($urandom));
          sent++;
        end
        [35:89]: begin
          limit = mode_wide ? 10 : 5;
          len   = $urandom_range(1, limit);
          for (int i = 0; i < len; i++) begin
            // drop an encode into the middle of the stream now and then
            if ($urandom_range(0, 9) == 0) begin
              send_item(FUNC_ENCODE, {$urandom, $urandom}, 8'($urandom));
              sent++;
            end
            top = (i < len - 1) ? 1'b1 : ((len == limit) ? 1'($urandom) : 1'b0);
            send_item(FUNC_DECODE, {$urandom, $urandom}, {top, 7'($urandom)});
            sent++;
          end
        end
        default: begin
          send_item(FUNC_DECODE, {$urandom, $urandom}, 8'($urandom));
          sent++;
        end
      endcase
      if ($urandom_range(0, 59) == 0)
        wait_drain();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_ENCODE;
    in_ch.value   = 64'd0;
    in_ch.in_byte = 8'd0;
    out_ch.ready  = 1'b0;
    mode_wide     = 1'b1;
    mode_zigzag   = 1'b0;
    acc_bits      = 64'd0;
    acc_count     = 4'd0;
    idle_enabled  = 1'b1;
    error_count   = 0;
    cycle_count   = 0;
    results_checked = 0;
    enc_items     = 0;
    dec_items     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_encode_extremes();
    test_decode_tenth_byte();
    test_zigzag_extremes();
    test_width_switch_mid_value();
    test_random_traffic(1'b1, 1'b0, 1'b0, 100);
    test_random_traffic(1'b1, 1'b1, 1'b1, 100);
    test_random_traffic(1'b0, 1'b0, 1'b1, 100);
    test_random_traffic(1'b0, 1'b1, 1'b1, 100);
    wait_drain();
    repeat (20) @(negedge clk);

    $display("Sent %0d encode values and %0d decode bytes; checked %0d results.",
             enc_items, dec_items, results_checked);
    $display("Settings covered: 32/64-bit with zigzag off and on, width change mid-value.");
    if (error_count == 0) begin
      $display("PASS varint_zigzag_codec_top");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL varint_zigzag_codec_top");
    end
    $finish;
  end

endmodule
